// File: rtl/tsr_pkg.sv
// tsr_pkg: shared types and constants of the token sequence replacer
`default_nettype none

package tsr_pkg;

	// fixed field widths
	localparam int unsigned TokW    = 31;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned LenW    = 3;
	localparam int unsigned NumWords = 6;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_PATTERN_LENGTH = 3'd0,
		CFG_REPLACEMENT_ID = 3'd1,
		CFG_PATTERN_WORD_0 = 3'd2,
		CFG_PATTERN_WORD_1 = 3'd3,
		CFG_PATTERN_WORD_2 = 3'd4,
		CFG_PATTERN_WORD_3 = 3'd5,
		CFG_PATTERN_WORD_4 = 3'd6,
		CFG_PATTERN_WORD_5 = 3'd7
	} tsr_cfg_idx_t;

	// input transaction payload
	typedef struct packed {
		logic [TokW-1:0] token_in;
		logic            text_end;
		logic            replace_enable;
	} tsr_in_item_t;

	// output transaction payload
	typedef struct packed {
		logic [TokW-1:0] token_out;
		logic            text_last;
	} tsr_out_item_t;

	// controller state
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} tsr_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
	} tsr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic emit;
		logic out_free;
	} tsr_status_t;

endpackage

`default_nettype wire

// File: rtl/tsr_ctrl.sv
// tsr_ctrl: sequencing state machine of the token sequence replacer
`default_nettype none

module tsr_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire tsr_pkg::tsr_status_t sts,
	output tsr_pkg::tsr_cmd_t        cmd
);
	import tsr_pkg::*;

	tsr_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (!sts.emit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_RUN: begin
				cmd.step = sts.emit && sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/tsr_datapath.sv
// tsr_datapath: configuration, token window, pattern compare and result register
`default_nettype none

module tsr_datapath #(
	parameter int MAX_PATTERN = 6,
	parameter int TOKEN_BITS  = 31
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [tsr_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [tsr_pkg::TokW-1:0]    cfg_data,
	input  wire tsr_pkg::tsr_in_item_t       in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output tsr_pkg::tsr_out_item_t           out_data,
	input  wire tsr_pkg::tsr_cmd_t           cmd,
	output tsr_pkg::tsr_status_t             sts
);
	import tsr_pkg::*;

	localparam int SB = (TOKEN_BITS < int'(TokW)) ? TOKEN_BITS : int'(TokW);
	localparam int CW = $clog2(MAX_PATTERN + 1);
	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	// configuration registers
	logic [LenW-1:0] len_q;
	logic [TokW-1:0] repl_q;
	logic [TokW-1:0] pat_q [NumWords];

	// token window: buffered prefix plus the newest token
	logic [SB-1:0]   work_q [MAX_PATTERN];
	logic [CW-1:0]   count_q;
	logic            en_q;
	logic            last_q;

	// result register
	logic            out_valid_q;
	tsr_out_item_t   out_data_q;

	logic [CW-1:0]   len_eff;
	logic            prefix;
	logic            full;
	logic            emit_front;
	logic            out_free;

	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LenW'(1);
			repl_q <= TokW'(1);
			for (int i = 0; i < int'(NumWords); i++) pat_q[i] <= '0;
		end else if (cfg_valid) begin
			unique case (tsr_cfg_idx_t'(cfg_index))
				CFG_PATTERN_LENGTH: len_q     <= cfg_data[LenW-1:0];
				CFG_REPLACEMENT_ID: repl_q    <= cfg_data;
				CFG_PATTERN_WORD_0: pat_q[0]  <= cfg_data;
				CFG_PATTERN_WORD_1: pat_q[1]  <= cfg_data;
				CFG_PATTERN_WORD_2: pat_q[2]  <= cfg_data;
				CFG_PATTERN_WORD_3: pat_q[3]  <= cfg_data;
				CFG_PATTERN_WORD_4: pat_q[4]  <= cfg_data;
				CFG_PATTERN_WORD_5: pat_q[5]  <= cfg_data;
				default: len_q <= len_q;
			endcase
		end
	end

	// clamp pattern length into 1..MAX_PATTERN
	always_comb begin
		if (len_q == '0) begin
			len_eff = CW'(1);
		end else if (int'(len_q) > MAX_PATTERN) begin
			len_eff = CW'(MAX_PATTERN);
		end else begin
			len_eff = CW'(len_q);
		end
	end

	// window against pattern prefix, all positions at once
	always_comb begin
		prefix = (count_q <= len_eff);
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if ((CW'(i) < count_q) && (work_q[i] != pat_q[i][SB-1:0])) prefix = 1'b0;
		end
	end

	// one decision per cycle: replacement, emit oldest token, or finished
	assign full       = en_q && prefix && (count_q == len_eff) && (count_q != '0);
	assign emit_front = (count_q != '0) && !full && (!en_q || !prefix || last_q);
	assign out_free   = !out_valid_q || out_ready;

	assign sts.emit     = full || emit_front;
	assign sts.out_free = out_free;

	// window control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			en_q    <= 1'b0;
			last_q  <= 1'b0;
		end else if (cmd.load) begin
			count_q <= count_q + CW'(1);
			en_q    <= in_data.replace_enable;
			last_q  <= in_data.text_end;
		end else if (cmd.step) begin
			if (full) begin
				count_q <= '0;
			end else begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// window contents: append on load, shift out the oldest on emit
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q[count_q[IW-1:0]] <= in_data.token_in[SB-1:0];
		end else if (cmd.step && emit_front) begin
			for (int i = 0; i < MAX_PATTERN - 1; i++) work_q[i] <= work_q[i+1];
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			out_data_q.token_out <= full ? repl_q : TokW'(work_q[0]);
			out_data_q.text_last <= last_q && (full || (count_q == CW'(1)));
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// File: rtl/token_sequence_replacer_core.sv
// token_sequence_replacer_core: top level of the stream pattern find-and-replace block
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_data    (token_in, text_end, replace_enable)
// out       output     out_valid / out_ready  out_data   (token_out, text_last)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// idle loads one transaction; run then gives one result per step and closes on a pass with
// no result; one result per cycle while out_ready allows: oldest token or replacement
// an item gives 0 to MAX_PATTERN results; new input waits until the window settles
// a result waits in the output register; out_ready low holds the shifter in place
// arst_n clears the window and loads the register reset values; no clearing pass
`default_nettype none

module token_sequence_replacer_core #(
	parameter int MAX_PATTERN = 6,
	parameter int TOKEN_BITS  = 31
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire tsr_pkg::tsr_in_item_t       in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output tsr_pkg::tsr_out_item_t           out_data,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [tsr_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [tsr_pkg::TokW-1:0]    cfg_data
);
	import tsr_pkg::*;

	tsr_cmd_t    cmd;
	tsr_status_t sts;

	// sequencing
	tsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// window and compare
	tsr_datapath #(
		.MAX_PATTERN (MAX_PATTERN),
		.TOKEN_BITS  (TOKEN_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire
